/* design/lfpid_pkg.sv */
// Shared widths, register indexes and reset values of the line-follow PID steering block.
package lfpid_pkg;

	// Field widths
	localparam int SAMPLE_W   = 7;
	localparam int SPEED_W    = 7;
	localparam int TARGET_W   = 8;
	localparam int LEVEL_W    = 7;
	localparam int GAIN_W     = 28;
	localparam int DRIVE_W    = 8;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 28;

	// Internal widths
	localparam int INTEG_W    = 32;
	localparam int ERR_W      = 8;
	localparam int LAST_W     = 9;
	localparam int DIFF_W     = 9;
	localparam int WIDE_E_W   = 10;
	localparam int SMALL_W    = 11;
	localparam int ACC_W      = 35;
	localparam int TURN_W     = 41;
	localparam int PHI_W      = 16;
	localparam int QUO_W      = 23;
	localparam int REM_W      = 4;
	localparam int CNT_W      = 6;

	localparam int DRIVE_MAX  = 100;
	localparam int DIVISOR    = 10;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET = 3'd0,
		REG_WHITE  = 3'd1,
		REG_GRAY   = 3'd2,
		REG_SIDE   = 3'd3,
		REG_GAIN_P = 3'd4,
		REG_GAIN_I = 3'd5,
		REG_GAIN_D = 3'd6
	} cfg_reg_t;

	localparam logic [TARGET_W-1:0] TARGET_RST = 8'd97;
	localparam logic [LEVEL_W-1:0]  WHITE_RST  = 7'd60;
	localparam logic [LEVEL_W-1:0]  GRAY_RST   = 7'd37;
	localparam logic                SIDE_RST   = 1'b1;
	localparam logic [GAIN_W-1:0]   GAIN_P_RST = 28'd3355443;
	localparam logic [GAIN_W-1:0]   GAIN_I_RST = 28'd168;
	localparam logic [GAIN_W-1:0]   GAIN_D_RST = 28'd587203;

endpackage

/* design/line_follow_pid_steering_top.sv */
// Line-follow PID steering block: error clamp, integral, bit-serial PID and drive scaling.
//
// After a word is accepted, the error, its clamp and the integral update are registered at the
// accepting edge. Then come a bit-serial multiply that walks the gain bits (all three gains feed
// one accumulator), a serial pass that streams the turn magnitude bit by bit against the base
// speed, a restoring divide by ten, and a final step to saturate and register the drives. The
// next word can be taken on the cycle after the result is registered; a new word is not taken
// while one is in flight. A result waiting in the output register does not hold off the next
// word. It only holds that word's final step until the output register is free.
// Configuration writes are taken at any time but must only be made while the block is idle.
module line_follow_pid_steering_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [lfpid_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lfpid_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [lfpid_pkg::SAMPLE_W-1:0]       light_sample,
	input  logic [lfpid_pkg::SPEED_W-1:0]        base_speed,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [lfpid_pkg::DRIVE_W-1:0] left_drive,
	output logic signed [lfpid_pkg::DRIVE_W-1:0] right_drive,
	output logic                                 drive_clipped
);
	import lfpid_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_SCALE,
		S_DIV,
		S_FIN
	} state_t;

	localparam logic [CNT_W-1:0] MUL_LAST   = CNT_W'(GAIN_W - 1);
	localparam logic [CNT_W-1:0] SCALE_LAST = CNT_W'(TURN_W - 1);
	localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(QUO_W - 1);
	localparam logic signed [WIDE_E_W-1:0] DLIM = WIDE_E_W'(DRIVE_MAX);
	localparam logic [TURN_W-1:0] TURN_CAP  = {1'b1, {(TURN_W-1){1'b0}}};

	// Configuration registers
	logic [TARGET_W-1:0] target_q;
	logic [LEVEL_W-1:0]  white_q;
	logic [LEVEL_W-1:0]  gray_q;
	logic                side_q;
	logic [GAIN_W-1:0]   gain_p_q;
	logic [GAIN_W-1:0]   gain_i_q;
	logic [GAIN_W-1:0]   gain_d_q;

	// Control and state
	state_t               state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 out_valid_q;
	logic [INTEG_W-1:0]   integ_q;
	logic [LAST_W-1:0]    last_q;
	logic [DRIVE_W-1:0]   left_q;
	logic [DRIVE_W-1:0]   right_q;
	logic                 clipped_q;

	// Datapath
	logic [ERR_W-1:0]     e_q;
	logic [DIFF_W-1:0]    d_q;
	logic [SPEED_W-1:0]   speed_q;
	logic [ACC_W-1:0]     acc_q;
	logic [GAIN_W-1:0]    lo_q;
	logic [TURN_W-1:0]    t_q;
	logic                 negser_q;
	logic                 tneg_q;
	logic                 seen_q;
	logic [SPEED_W-1:0]   pacc_q;
	logic [PHI_W-1:0]     phi_q;
	logic [QUO_W-1:0]     dv_q;
	logic [REM_W-1:0]     rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RST;
			white_q  <= WHITE_RST;
			gray_q   <= GRAY_RST;
			side_q   <= SIDE_RST;
			gain_p_q <= GAIN_P_RST;
			gain_i_q <= GAIN_I_RST;
			gain_d_q <= GAIN_D_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TARGET: target_q <= cfg_data[TARGET_W-1:0];
				REG_WHITE:  white_q  <= cfg_data[LEVEL_W-1:0];
				REG_GRAY:   gray_q   <= cfg_data[LEVEL_W-1:0];
				REG_SIDE:   side_q   <= cfg_data[0];
				REG_GAIN_P: gain_p_q <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I: gain_i_q <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D: gain_d_q <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	logic in_fire;
	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;

	// Error, clamp and integral update for the incoming word
	logic signed [WIDE_E_W-1:0] raw_e, side_e, lim_s, clamp_e;
	logic [LEVEL_W-1:0]         lim;
	logic [ERR_W-1:0]           e_new;
	logic [INTEG_W:0]           isum;
	logic [INTEG_W-1:0]         integ_new;
	logic [DIFF_W-1:0]          d_new;

	always_comb begin
		raw_e   = $signed({2'b00, light_sample, 1'b0}) - $signed({2'b00, target_q});
		side_e  = side_q ? -raw_e : raw_e;
		lim     = (white_q > gray_q) ? white_q - gray_q : '0;
		lim_s   = $signed({3'b000, lim});
		if (side_e > lim_s)
			clamp_e = lim_s;
		else if (side_e < -lim_s)
			clamp_e = -lim_s;
		else
			clamp_e = side_e;
		e_new = clamp_e[ERR_W-1:0];
		isum  = {integ_q[INTEG_W-1], integ_q}
			+ {{(INTEG_W+1-ERR_W){e_new[ERR_W-1]}}, e_new};
		// saturate on overflow of the signed 32-bit range
		if (isum[INTEG_W] != isum[INTEG_W-1])
			integ_new = isum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
				: {1'b0, {(INTEG_W-1){1'b1}}};
		else
			integ_new = isum[INTEG_W-1:0];
		d_new = {e_new[ERR_W-1], e_new} - last_q;
	end

	// Bit-serial multiply: one gain bit per cycle, LSB first
	logic [4:0]         kidx;
	logic [SMALL_W-1:0] pd;
	logic [ACC_W-1:0]   add_w, acc_nx;
	logic [GAIN_W-1:0]  lo_nx;
	logic               in_range;

	always_comb begin
		kidx = cnt_q[4:0];
		pd = (gain_p_q[kidx] ? {{(SMALL_W-ERR_W){e_q[ERR_W-1]}}, e_q} : '0)
			+ (gain_d_q[kidx] ? {{(SMALL_W-DIFF_W){d_q[DIFF_W-1]}}, d_q} : '0);
		add_w = acc_q
			+ (gain_i_q[kidx] ? {{(ACC_W-INTEG_W){integ_q[INTEG_W-1]}}, integ_q} : '0)
			+ {{(ACC_W-SMALL_W){pd[SMALL_W-1]}}, pd};
		acc_nx = {add_w[ACC_W-1], add_w[ACC_W-1:1]};
		lo_nx  = {add_w[0], lo_q[GAIN_W-1:1]};
		// turn fits 41 signed bits when the high part is a pure sign extension
		in_range = (&acc_nx[ACC_W-1:TURN_W-GAIN_W-1])
			|| !(|acc_nx[ACC_W-1:TURN_W-GAIN_W-1]);
	end

	// Serial magnitude times speed; negate on the fly when the turn is negative
	logic               tb, mb;
	logic [SPEED_W:0]   psum;

	always_comb begin
		tb   = t_q[0];
		mb   = negser_q ? (tb ^ seen_q) : tb;
		psum = {1'b0, pacc_q} + (mb ? {1'b0, speed_q} : '0);
	end

	// Restoring divide by ten, one quotient bit per cycle
	logic [REM_W:0] r5;
	logic           ge;

	always_comb begin
		r5 = {rem_q, dv_q[QUO_W-1]};
		ge = (r5 >= (REM_W+1)'(DIVISOR));
	end

	// Drive saturation
	logic [DRIVE_W-1:0]         tc;
	logic signed [WIDE_E_W-1:0] tcs, spd, left_raw, right_raw, left_sat, right_sat;
	logic                       clip_nx;

	always_comb begin
		tc  = (|dv_q[QUO_W-1:DRIVE_W]) ? '1 : dv_q[DRIVE_W-1:0];
		tcs = tneg_q ? -$signed({2'b00, tc}) : $signed({2'b00, tc});
		spd = $signed({3'b000, speed_q});
		left_raw  = -spd - tcs;
		right_raw = -spd + tcs;
		clip_nx   = 1'b0;
		left_sat  = left_raw;
		right_sat = right_raw;
		if (left_raw > DLIM) begin
			left_sat = DLIM;
			clip_nx  = 1'b1;
		end else if (left_raw < -DLIM) begin
			left_sat = -DLIM;
			clip_nx  = 1'b1;
		end
		if (right_raw > DLIM) begin
			right_sat = DLIM;
			clip_nx   = 1'b1;
		end else if (right_raw < -DLIM) begin
			right_sat = -DLIM;
			clip_nx   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			integ_q     <= '0;
			last_q      <= '0;
			left_q      <= '0;
			right_q     <= '0;
			clipped_q   <= 1'b0;
		end else begin
			// drop the taken word unless the finish step loads a new one
			if (out_valid_q && out_ready && state_q != S_FIN)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						integ_q <= integ_new;
						last_q  <= {e_new[ERR_W-1], e_new};
						cnt_q   <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (cnt_q == MUL_LAST) begin
						cnt_q   <= '0;
						state_q <= S_SCALE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_SCALE: begin
					if (cnt_q == SCALE_LAST) begin
						cnt_q   <= '0;
						state_q <= S_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DIV: begin
					if (cnt_q == DIV_LAST) begin
						cnt_q   <= '0;
						state_q <= S_FIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_FIN: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						left_q      <= left_sat[DRIVE_W-1:0];
						right_q     <= right_sat[DRIVE_W-1:0];
						clipped_q   <= clip_nx;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					e_q     <= e_new;
					d_q     <= d_new;
					speed_q <= base_speed;
					acc_q   <= '0;
				end
			end
			S_MUL: begin
				acc_q <= acc_nx;
				lo_q  <= lo_nx;
				if (cnt_q == MUL_LAST) begin
					tneg_q   <= acc_nx[ACC_W-1];
					negser_q <= in_range && acc_nx[ACC_W-1];
					t_q      <= in_range ? {acc_nx[TURN_W-GAIN_W-1:0], lo_nx} : TURN_CAP;
					seen_q   <= 1'b0;
					pacc_q   <= '0;
				end
			end
			S_SCALE: begin
				t_q    <= {1'b0, t_q[TURN_W-1:1]};
				seen_q <= seen_q | tb;
				pacc_q <= psum[SPEED_W:1];
				phi_q  <= {psum[0], phi_q[PHI_W-1:1]};
				if (cnt_q == SCALE_LAST) begin
					// drop the 25 fraction bits: keep product bits 25 and up
					dv_q  <= {psum[SPEED_W:1], psum[0], phi_q[PHI_W-1:1]};
					rem_q <= '0;
				end
			end
			S_DIV: begin
				rem_q <= ge ? REM_W'(r5 - (REM_W+1)'(DIVISOR)) : r5[REM_W-1:0];
				dv_q  <= {dv_q[QUO_W-2:0], ge};
			end
			default: ;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign left_drive    = left_q;
	assign right_drive   = right_q;
	assign drive_clipped = clipped_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("block still ready after taking a word");

	a_left_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (left_drive <= 8'sd100) && (left_drive >= -8'sd100)
			&& (right_drive <= 8'sd100) && (right_drive >= -8'sd100))
		else $error("drive command outside saturation band");

	a_clip_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drive_clipped |-> (left_drive == 8'sd100) || (left_drive == -8'sd100)
			|| (right_drive == 8'sd100) || (right_drive == -8'sd100))
		else $error("clip flag set with no drive at its limit");

	a_mul_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL |-> cnt_q <= MUL_LAST)
		else $error("multiply counter past last gain bit");

	a_fin_to_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN && !out_valid_q |=> out_valid_q && in_ready)
		else $error("finished word not presented");

endmodule
